// File: rtl/sst_pkg.sv
// sst_pkg: shared types and constants for the session slot table.
// Action codes, the result transaction type and configuration register indexes.
// No dependencies.
package sst_pkg;

  typedef enum logic [2:0] {
    ACT_LOOKUP = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_BUMP   = 3'd2,
    ACT_KILL   = 3'd3,
    ACT_SWEEP  = 3'd4
  } action_t;

  // Configuration register indexes
  localparam int  CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ALIVE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KILL  = 1'd1;

  localparam logic [15:0] ALIVE_RESET = 16'd10;
  localparam logic [15:0] KILL_RESET  = 16'd5;

  // Sweep reports at most this many freed slots per input transaction
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [3:0] slot;
    logic       ok;
    logic       last;
  } res_t;

endpackage

// File: rtl/session_slot_table_with_aging.sv
// Session slot table with keepalive aging: top level. One item in flight at a time.
// Bump/kill rewrite one entry; lookup, add and sweep walk the slots (sweep up to the
// result limit). Throughput is set by the RAM read port (one slot per cycle while
// the output accepts) and the slot walk counter; new input is taken when idle.
// Reset (rst, synchronous): valid bits, round-robin pointer, timeouts (10, 5) and
// control state cleared at once; entry RAM is not cleared (read only for valid slots).
module session_slot_table_with_aging #(
  parameter int MAX_SLOTS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    action,
  input  logic [31:0]                   ip_address,
  input  logic [15:0]                   port,
  input  logic [3:0]                    slot_id,
  input  logic [31:0]                   now,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    result_slot,
  output logic                          ok,
  output logic                          last,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import sst_pkg::*;

  localparam int SW  = $clog2(MAX_SLOTS);
  // Saturating add width: room for a 16-bit timeout and a carry
  localparam int AW  = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;
  // Entry layout: {ip, port, deadline, locked}
  localparam int E_W = 32 + 16 + TIME_BITS + 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_SLOTS - 1);
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_ADD,
    S_UPD,
    S_SWEEP,
    S_FLUSH
  } state_t;

  function automatic logic [SW-1:0] slot_inc(logic [SW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SW'(1);
  endfunction

  function automatic logic [3:0] to_res_slot(logic [SW-1:0] s);
    logic [6:0] w;
    w = 7'(s);
    return w[3:0];
  endfunction

  state_t state;

  // config registers
  logic [15:0] alive_to;
  logic [15:0] kill_to;

  // table control state
  logic [MAX_SLOTS-1:0] valid;
  logic [SW-1:0]        next_slot;

  // walk state: rd_q always holds the entry at idx
  logic [SW-1:0]        idx;
  logic [SW-1:0]        cnt;
  logic [SW-1:0]        rd_addr;
  logic [E_W-1:0]       rd_q;

  // sweep holding stage: the latest freed slot waits until we know if it is last
  logic                 have_held;
  logic [SW-1:0]        held_slot;
  logic [RES_CNT_W-1:0] n_found;

  // latched transaction
  action_t              act_q;
  logic [31:0]          ip_q;
  logic [15:0]          port_q;
  logic                 id_ok_q;
  logic [TIME_BITS-1:0] now_q;

  // decode
  logic                 id_ok_in;
  logic                 in_acc;
  logic                 out_free;
  logic                 push;
  res_t                 res;
  logic                 advance;
  logic                 done;
  logic                 to_flush;
  logic                 take;
  logic                 mem_we;
  logic [E_W-1:0]       mem_wdata;

  // entry fields
  logic [31:0]          e_ip;
  logic [15:0]          e_port;
  logic [TIME_BITS-1:0] e_dl;
  logic                 e_lock;
  logic                 match;
  logic                 expired;
  logic                 upd_ok;
  logic                 is_last;
  logic                 sweep_full;

  // saturating deadline
  logic [15:0]          tmo;
  logic [AW-1:0]        dl_sum;
  logic [TIME_BITS-1:0] dl_new;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign id_ok_in  = 7'(slot_id) < 7'(MAX_SLOTS);

  assign e_ip    = rd_q[E_W-1 -: 32];
  assign e_port  = rd_q[E_W-33 -: 16];
  assign e_dl    = rd_q[TIME_BITS:1];
  assign e_lock  = rd_q[0];

  assign match      = valid[idx] && (e_ip == ip_q) && (e_port == port_q);
  assign expired    = valid[idx] && (e_dl < now_q);
  assign upd_ok     = id_ok_q && valid[idx] && !e_lock;
  assign is_last    = (idx == LAST_SLOT);
  assign sweep_full = ((n_found + RES_CNT_W'(1)) == RES_CNT_W'(MAX_RESULTS));

  // kill uses the short timeout, add and bump the alive timeout
  assign tmo    = (act_q == ACT_KILL) ? kill_to : alive_to;
  assign dl_sum = AW'(now_q) + AW'(tmo);
  assign dl_new = (dl_sum > AW'(TMAX)) ? TMAX : dl_sum[TIME_BITS-1:0];

  always_comb begin
    advance   = 1'b0;
    done      = 1'b0;
    to_flush  = 1'b0;
    take      = 1'b0;
    push      = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = {ip_q, port_q, dl_new, 1'b0};
    res       = '{slot: 4'd0, ok: 1'b0, last: 1'b1};
    unique case (state)
      S_IDLE: begin
      end
      S_LOOKUP: begin
        if (match) begin
          if (out_free) begin
            push = 1'b1;
            res  = '{slot: to_res_slot(idx), ok: 1'b1, last: 1'b1};
            done = 1'b1;
          end
        end else if (is_last) begin
          if (out_free) begin
            push = 1'b1;
            done = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
      end
      S_ADD: begin
        // first free slot at or after the round-robin pointer
        if (!valid[idx]) begin
          if (out_free) begin
            push   = 1'b1;
            res    = '{slot: to_res_slot(idx), ok: 1'b1, last: 1'b1};
            mem_we = 1'b1;
            done   = 1'b1;
          end
        end else if (cnt == LAST_SLOT) begin
          if (out_free) begin
            push = 1'b1;
            done = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
      end
      S_UPD: begin
        // read-modify-write of the addressed entry, keeps the endpoint
        if (out_free) begin
          push      = 1'b1;
          res       = '{slot: upd_ok ? to_res_slot(idx) : 4'd0, ok: upd_ok, last: 1'b1};
          mem_we    = upd_ok;
          mem_wdata = {e_ip, e_port, dl_new, (act_q == ACT_KILL)};
          done      = 1'b1;
        end
      end
      S_SWEEP: begin
        if (expired) begin
          if (!have_held || out_free) begin
            push = have_held;
            res  = '{slot: to_res_slot(held_slot), ok: 1'b1, last: 1'b0};
            take = 1'b1;
            if (is_last || sweep_full) begin
              to_flush = 1'b1;
            end else begin
              advance = 1'b1;
            end
          end
        end else if (is_last) begin
          to_flush = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          push = 1'b1;
          res  = '{slot: have_held ? to_res_slot(held_slot) : 4'd0, ok: have_held,
                   last: 1'b1};
          done = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // RAM read address; the registered read lands together with idx
  always_comb begin
    rd_addr = '0;
    if (state == S_IDLE) begin
      case (action) inside
        ACT_ADD:            rd_addr = next_slot;
        ACT_BUMP, ACT_KILL: rd_addr = id_ok_in ? SW'(slot_id) : '0;
        default:            rd_addr = '0;
      endcase
    end else begin
      rd_addr = advance ? slot_inc(idx) : idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      alive_to  <= ALIVE_RESET;
      kill_to   <= KILL_RESET;
      valid     <= '0;
      next_slot <= '0;
      idx       <= '0;
      cnt       <= '0;
      have_held <= 1'b0;
      held_slot <= '0;
      n_found   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ALIVE: alive_to <= cfg_data;
          REG_KILL:  kill_to  <= cfg_data;
          default: begin
          end
        endcase
      end

      idx <= rd_addr;

      if (in_acc) begin
        cnt       <= '0;
        have_held <= 1'b0;
        n_found   <= '0;
        unique case (action)
          ACT_LOOKUP: state <= S_LOOKUP;
          ACT_ADD:    state <= S_ADD;
          ACT_BUMP:   state <= S_UPD;
          ACT_KILL:   state <= S_UPD;
          ACT_SWEEP:  state <= S_SWEEP;
          default:    state <= S_FLUSH;
        endcase
      end

      if (advance) begin
        cnt <= cnt + SW'(1);
      end

      if (state == S_ADD && mem_we) begin
        valid[idx] <= 1'b1;
        next_slot  <= slot_inc(idx);
      end

      if (take) begin
        valid[idx] <= 1'b0;
        held_slot  <= idx;
        have_held  <= 1'b1;
        n_found    <= n_found + RES_CNT_W'(1);
      end

      if (to_flush) begin
        state <= S_FLUSH;
      end

      if (done) begin
        state     <= S_IDLE;
        have_held <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_q   <= action_t'(action);
      ip_q    <= ip_address;
      port_q  <= port;
      id_ok_q <= id_ok_in;
      now_q   <= TIME_BITS'(now);
    end
  end

  sst_entry_ram #(
    .DEPTH  (MAX_SLOTS),
    .DATA_W (E_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_q)
  );

  sst_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .res         (res),
    .free        (out_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_slot (result_slot),
    .ok          (ok),
    .last        (last)
  );

`ifndef ASSERT_OFF
  // never overwrite a result that is still waiting
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed into occupied output register");

  // a slot waiting to be reported by sweep is already freed
  a_held_freed: assert property (@(posedge clk) disable iff (rst)
    have_held |-> !valid[held_slot])
    else $error("held sweep slot still marked valid");

  // a successful add marks its slot occupied
  a_add_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD && push && res.ok) |=> valid[$past(idx)])
    else $error("added slot not marked valid");

  // sweep never reports more than the result limit
  a_sweep_cap: assert property (@(posedge clk) disable iff (rst)
    n_found <= RES_CNT_W'(MAX_RESULTS))
    else $error("sweep result count over limit");
`endif

endmodule

// File: rtl/sst_entry_ram.sv
// sst_entry_ram: single write port, single read port synchronous RAM.
// Read data is registered. No dependencies.
module sst_entry_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 81
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sst_out_reg.sv
// sst_out_reg: result output register with valid/stall handshake.
// Depends on sst_pkg (res_t).
module sst_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sst_pkg::res_t res,
  output logic          free,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [3:0]    result_slot,
  output logic          ok,
  output logic          last
);
  import sst_pkg::*;

  res_t held;

  // Room for a new transaction when empty or the current one leaves this cycle
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= res;
    end
  end

  assign result_slot = held.slot;
  assign ok          = held.ok;
  assign last        = held.last;

endmodule
